/* src/vna_pkg.sv */
package vna_pkg;

  // store geometry
  localparam int VERTEX_DEPTH = 1024;
  localparam int IDX_W        = $clog2(VERTEX_DEPTH);
  localparam int COORD_W      = 16;
  localparam int VTX_W        = 3 * COORD_W;

  // cross product widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int VEC_W  = PROD_W + 2;

  // accumulator entry: {sum_x, sum_y, sum_z, face_count}
  localparam int SUM_W = 24;
  localparam int CNT_W = 8;
  localparam int ACC_W = 3 * SUM_W + CNT_W;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // normaliser widths
  localparam int NRM_W = 16;
  localparam int FRAC  = 14;
  localparam int MAG_W = VEC_W;
  localparam int SCL_W = 30;
  localparam int SQ_W  = 2 * SCL_W + 3;
  localparam int LEN_W = 32;
  localparam int Q_W   = 16;
  localparam int DV_W  = LEN_W + Q_W - 1;
  localparam logic [Q_W-1:0]         ONE_Q   = Q_W'(1) << FRAC;
  localparam logic [NRM_W-1:0]       ONE_Q14 = NRM_W'(1) << FRAC;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_WRITE    = 2'd1,
    FUNC_TRIANGLE = 2'd2,
    FUNC_READ     = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_VRD,
    S_DIFF,
    S_CROSS,
    S_NST,
    S_NWT,
    S_ACC,
    S_RDA,
    S_PUT
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQ,
    N_ROOT,
    N_DIV,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic                  start;
    logic [2:0][VEC_W-1:0] vec;
  } norm_req_t;

  typedef struct packed {
    logic                  done;
    logic                  nonzero;
    logic [2:0][NRM_W-1:0] n;
  } norm_rsp_t;

endpackage

/* src/vna_cmd_if.sv */
interface vna_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [vna_pkg::IDX_W-1:0]         vertex_index;
  logic signed [vna_pkg::COORD_W-1:0] pos_x;
  logic signed [vna_pkg::COORD_W-1:0] pos_y;
  logic signed [vna_pkg::COORD_W-1:0] pos_z;
  logic [vna_pkg::IDX_W-1:0]         first_corner;
  logic [vna_pkg::IDX_W-1:0]         second_corner;
  logic [vna_pkg::IDX_W-1:0]         third_corner;

  modport source (
    output valid, func, vertex_index, pos_x, pos_y, pos_z,
           first_corner, second_corner, third_corner,
    input  ready
  );
  modport sink (
    input  valid, func, vertex_index, pos_x, pos_y, pos_z,
           first_corner, second_corner, third_corner,
    output ready
  );
endinterface

/* src/vna_res_if.sv */
interface vna_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [vna_pkg::NRM_W-1:0]   normal_x;
  logic signed [vna_pkg::NRM_W-1:0]   normal_y;
  logic signed [vna_pkg::NRM_W-1:0]   normal_z;
  logic                               used_default;
  logic                               count_saturated;

  modport source (
    output valid, normal_x, normal_y, normal_z, used_default, count_saturated,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, used_default, count_saturated,
    output ready
  );
endinterface

/* src/vertex_normal_accumulator.sv */
// Vertex normal accumulator
//
// cmd channel (sink): one item per transfer. func selects clear accumulators,
// write vertex position, add triangle (three corner indices) or read normal.
// res channel (source): one result per read item, a Q1.14 unit normal with
// used_default and count_saturated flags; other items give no result.
//
// After reset the block sweeps the accumulator memory to zero, one entry a
// cycle, with cmd.ready low. A clear item runs the same sweep.
// A vertex write is stored as it is taken. A triangle keeps cmd.ready low
// after its transfer while it runs: vertex reads, differences, six products
// on one multiplier, a start of the shared normaliser (scaling shift, sum of
// squares, bit-serial square root, one bit-serial division per component,
// finish; a degenerate triangle goes from scaling straight to finish),
// then three read-modify-write passes on the accumulator memory.
// A read skips the normaliser when the vertex has no faces and stops it after
// scaling when its sums are zero; the result is registered in its last cycle.
// One item is in work at a time. The result sits in an output register; a
// stalled receiver holds it there while the next item is taken, and a later
// read waits for the register to empty before finishing.
module vertex_normal_accumulator (
  input  logic       clk,
  input  logic       rst,
  vna_cmd_if.sink    cmd,
  vna_res_if.source  res
);

  vna_pkg::top_state_t st, st_next;
  logic [2:0]                      cnt;
  logic [2:0]                      xidx;
  logic [1:0]                      vsel;
  logic [1:0]                      pidx;
  logic [vna_pkg::IDX_W-1:0]       clr_cnt;
  logic [vna_pkg::IDX_W-1:0]       k [3];
  logic signed [vna_pkg::COORD_W-1:0] p [3][3];
  logic signed [vna_pkg::DIFF_W-1:0]  da [3];
  logic signed [vna_pkg::DIFF_W-1:0]  db [3];
  logic signed [vna_pkg::DIFF_W-1:0]  ma, mb;
  logic signed [vna_pkg::PROD_W-1:0]  prod;
  logic [vna_pkg::VEC_W-1:0]       vec [3];
  logic [vna_pkg::NRM_W-1:0]       nv [3];
  logic                            is_read;
  logic                            rd_sat;
  logic                            dflt;
  logic                            load;

  // memory ports
  logic                            vwe;
  logic [vna_pkg::IDX_W-1:0]       vwaddr, vraddr;
  logic [vna_pkg::VTX_W-1:0]       vwdata, vrdata;
  logic                            awe;
  logic [vna_pkg::IDX_W-1:0]       awaddr, araddr;
  logic [vna_pkg::ACC_W-1:0]       awdata, ardata, acc_new;
  logic [vna_pkg::SUM_W-1:0]       e_x, e_y, e_z;
  logic [vna_pkg::CNT_W-1:0]       e_c;

  vna_pkg::norm_req_t nreq;
  vna_pkg::norm_rsp_t nrsp;

  function automatic logic [vna_pkg::SUM_W-1:0] sat_add(
    input logic [vna_pkg::SUM_W-1:0] a,
    input logic [vna_pkg::NRM_W-1:0] b
  );
    logic [vna_pkg::SUM_W:0] r;
    r = {a[vna_pkg::SUM_W-1], a}
        + {{(vna_pkg::SUM_W + 1 - vna_pkg::NRM_W){b[vna_pkg::NRM_W-1]}}, b};
    if (r[vna_pkg::SUM_W] != r[vna_pkg::SUM_W-1]) begin
      sat_add = r[vna_pkg::SUM_W] ? {1'b1, {(vna_pkg::SUM_W-1){1'b0}}}
                                  : {1'b0, {(vna_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat_add = r[vna_pkg::SUM_W-1:0];
    end
  endfunction

  vna_ram #(.WIDTH(vna_pkg::VTX_W), .DEPTH(vna_pkg::VERTEX_DEPTH)) u_vtx_ram (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vraddr), .rdata(vrdata)
  );

  vna_ram #(.WIDTH(vna_pkg::ACC_W), .DEPTH(vna_pkg::VERTEX_DEPTH)) u_acc_ram (
    .clk(clk), .we(awe), .waddr(awaddr), .wdata(awdata), .raddr(araddr), .rdata(ardata)
  );

  vna_norm u_norm (.clk(clk), .rst(rst), .req(nreq), .rsp(nrsp));

  // accumulator entry fields and updated entry
  assign e_x  = ardata[vna_pkg::ACC_W-1 -: vna_pkg::SUM_W];
  assign e_y  = ardata[vna_pkg::ACC_W-1-vna_pkg::SUM_W -: vna_pkg::SUM_W];
  assign e_z  = ardata[vna_pkg::CNT_W +: vna_pkg::SUM_W];
  assign e_c  = ardata[vna_pkg::CNT_W-1:0];
  assign acc_new = {sat_add(e_x, nv[0]), sat_add(e_y, nv[1]), sat_add(e_z, nv[2]),
                    (e_c == vna_pkg::COUNT_MAX) ? e_c : e_c + 1'b1};

  assign xidx = cnt - 3'd1;
  assign pidx = cnt[1:0] - 2'd1;
  assign vsel = (cnt[1:0] == 2'd3) ? 2'd2 : cnt[1:0];

  // product selection for the cross product
  always_comb begin
    unique case (cnt)
      3'd0:    begin ma = da[1]; mb = db[2]; end
      3'd1:    begin ma = da[2]; mb = db[1]; end
      3'd2:    begin ma = da[2]; mb = db[0]; end
      3'd3:    begin ma = da[0]; mb = db[2]; end
      3'd4:    begin ma = da[0]; mb = db[1]; end
      default: begin ma = da[1]; mb = db[0]; end
    endcase
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      vna_pkg::S_CLEAR: begin
        if (clr_cnt == vna_pkg::IDX_W'(vna_pkg::VERTEX_DEPTH - 1)) st_next = vna_pkg::S_IDLE;
      end
      vna_pkg::S_IDLE: begin
        if (cmd.valid) begin
          unique case (vna_pkg::func_t'(cmd.func))
            vna_pkg::FUNC_CLEAR:    st_next = vna_pkg::S_CLEAR;
            vna_pkg::FUNC_WRITE:    st_next = vna_pkg::S_IDLE;
            vna_pkg::FUNC_TRIANGLE: st_next = vna_pkg::S_VRD;
            vna_pkg::FUNC_READ:     st_next = vna_pkg::S_RDA;
          endcase
        end
      end
      vna_pkg::S_VRD:   if (cnt == 3'd3) st_next = vna_pkg::S_DIFF;
      vna_pkg::S_DIFF:  st_next = vna_pkg::S_CROSS;
      vna_pkg::S_CROSS: if (cnt == 3'd6) st_next = vna_pkg::S_NST;
      vna_pkg::S_NST:   st_next = vna_pkg::S_NWT;
      vna_pkg::S_NWT: begin
        if (nrsp.done) st_next = is_read ? vna_pkg::S_PUT : vna_pkg::S_ACC;
      end
      vna_pkg::S_ACC:   if (cnt == 3'd5) st_next = vna_pkg::S_IDLE;
      vna_pkg::S_RDA:   st_next = (e_c == '0) ? vna_pkg::S_PUT : vna_pkg::S_NST;
      vna_pkg::S_PUT:   if (!res.valid || res.ready) st_next = vna_pkg::S_IDLE;
      default:          st_next = vna_pkg::S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    cmd.ready  = 1'b0;
    vwe        = 1'b0;
    vwaddr     = cmd.vertex_index;
    vwdata     = {cmd.pos_x, cmd.pos_y, cmd.pos_z};
    vraddr     = k[vsel];
    awe        = 1'b0;
    awaddr     = clr_cnt;
    awdata     = '0;
    araddr     = cmd.vertex_index;
    nreq.start = 1'b0;
    for (int i = 0; i < 3; i++) nreq.vec[i] = vec[i];
    load       = 1'b0;
    unique case (st)
      vna_pkg::S_CLEAR: awe = 1'b1;
      vna_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        vwe = cmd.valid && (vna_pkg::func_t'(cmd.func) == vna_pkg::FUNC_WRITE);
      end
      vna_pkg::S_ACC: begin
        araddr = k[cnt[2:1]];
        awaddr = k[cnt[2:1]];
        awdata = acc_new;
        awe    = cnt[0];
      end
      vna_pkg::S_NST: nreq.start = 1'b1;
      vna_pkg::S_PUT: load = !res.valid || res.ready;
      default: ;
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= vna_pkg::S_CLEAR;
      cnt       <= '0;
      clr_cnt   <= '0;
      res.valid <= 1'b0;
    end else begin
      st      <= st_next;
      cnt     <= (st != st_next) ? 3'd0 : cnt + 3'd1;
      clr_cnt <= (st == vna_pkg::S_CLEAR) ? clr_cnt + 1'b1 : '0;
      if (load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st)
      vna_pkg::S_IDLE: begin
        k[0]    <= cmd.first_corner;
        k[1]    <= cmd.second_corner;
        k[2]    <= cmd.third_corner;
        is_read <= (vna_pkg::func_t'(cmd.func) == vna_pkg::FUNC_READ);
      end
      vna_pkg::S_VRD: begin
        if (cnt != 3'd0) begin
          p[pidx][0] <= vrdata[vna_pkg::VTX_W-1 -: vna_pkg::COORD_W];
          p[pidx][1] <= vrdata[vna_pkg::COORD_W +: vna_pkg::COORD_W];
          p[pidx][2] <= vrdata[vna_pkg::COORD_W-1:0];
        end
      end
      vna_pkg::S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          da[i] <= {p[1][i][vna_pkg::COORD_W-1], p[1][i]}
                   - {p[0][i][vna_pkg::COORD_W-1], p[0][i]};
          db[i] <= {p[1][i][vna_pkg::COORD_W-1], p[1][i]}
                   - {p[2][i][vna_pkg::COORD_W-1], p[2][i]};
        end
      end
      vna_pkg::S_CROSS: begin
        if (cnt < 3'd6) begin
          prod <= ma * mb;
        end
        if (cnt != 3'd0) begin
          if (!xidx[0]) begin
            vec[xidx[2:1]] <= {{(vna_pkg::VEC_W-vna_pkg::PROD_W){prod[vna_pkg::PROD_W-1]}}, prod};
          end else begin
            vec[xidx[2:1]] <= vec[xidx[2:1]]
              - {{(vna_pkg::VEC_W-vna_pkg::PROD_W){prod[vna_pkg::PROD_W-1]}}, prod};
          end
        end
      end
      vna_pkg::S_RDA: begin
        vec[0] <= {{(vna_pkg::VEC_W-vna_pkg::SUM_W){e_x[vna_pkg::SUM_W-1]}}, e_x};
        vec[1] <= {{(vna_pkg::VEC_W-vna_pkg::SUM_W){e_y[vna_pkg::SUM_W-1]}}, e_y};
        vec[2] <= {{(vna_pkg::VEC_W-vna_pkg::SUM_W){e_z[vna_pkg::SUM_W-1]}}, e_z};
        rd_sat <= (e_c == vna_pkg::COUNT_MAX);
        dflt   <= (e_c == '0);
      end
      vna_pkg::S_NWT: begin
        if (nrsp.done) begin
          for (int i = 0; i < 3; i++) nv[i] <= nrsp.n[i];
          dflt <= !nrsp.nonzero;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      res.normal_x        <= dflt ? '0 : nv[0];
      res.normal_y        <= dflt ? '0 : nv[1];
      res.normal_z        <= dflt ? vna_pkg::ONE_Q14 : nv[2];
      res.used_default    <= dflt;
      res.count_saturated <= rd_sat;
    end
  end

endmodule

/* src/vna_ram.sv */
module vna_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/vna_norm.sv */
module vna_norm (
  input  logic               clk,
  input  logic               rst,
  input  vna_pkg::norm_req_t req,
  output vna_pkg::norm_rsp_t rsp
);

  vna_pkg::norm_state_t nst, nst_next;
  logic [4:0] cnt;
  logic [1:0] comp;
  logic [1:0] sel;
  logic       div_last;
  logic       nonzero;

  logic [vna_pkg::MAG_W-1:0]     mag [3];
  logic [2:0]                    neg;
  logic [vna_pkg::MAG_W-1:0]     m;
  logic [2*vna_pkg::SCL_W-1:0]   prod;
  logic [vna_pkg::SQ_W-1:0]      rem, root, bitr, trial;
  logic [vna_pkg::DV_W-1:0]      drem, dvs, num;
  logic [vna_pkg::Q_W-1:0]       q, qc;
  logic [2:0][vna_pkg::NRM_W-1:0] nout;

  // largest magnitude
  always_comb begin
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
  end

  assign sel      = (cnt[1:0] == 2'd3) ? 2'd2 : cnt[1:0];
  assign trial    = root + bitr;
  assign num      = (vna_pkg::DV_W'(mag[comp][vna_pkg::SCL_W-1:0]) << vna_pkg::FRAC)
                    + vna_pkg::DV_W'(root[vna_pkg::LEN_W-1:1]);
  assign qc       = (q > vna_pkg::ONE_Q) ? vna_pkg::ONE_Q : q;
  assign div_last = (nst == vna_pkg::N_DIV) && (cnt == 5'd17);

  // next state
  always_comb begin
    nst_next = nst;
    unique case (nst)
      vna_pkg::N_IDLE:  if (req.start) nst_next = vna_pkg::N_SCALE;
      vna_pkg::N_SCALE: begin
        if (m == '0) begin
          nst_next = vna_pkg::N_DONE;
        end else if (m[vna_pkg::MAG_W-1:vna_pkg::SCL_W] == '0 && m[vna_pkg::SCL_W-1]) begin
          nst_next = vna_pkg::N_SQ;
        end
      end
      vna_pkg::N_SQ:    if (cnt == 5'd3) nst_next = vna_pkg::N_ROOT;
      vna_pkg::N_ROOT:  if (cnt == 5'd31) nst_next = vna_pkg::N_DIV;
      vna_pkg::N_DIV:   if (div_last && comp == 2'd2) nst_next = vna_pkg::N_DONE;
      vna_pkg::N_DONE:  nst_next = vna_pkg::N_IDLE;
      default:          nst_next = vna_pkg::N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done    = (nst == vna_pkg::N_DONE);
    rsp.nonzero = nonzero;
    rsp.n       = nout;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      nst  <= vna_pkg::N_IDLE;
      cnt  <= '0;
      comp <= '0;
    end else begin
      nst <= nst_next;
      cnt <= (nst != nst_next || div_last) ? 5'd0 : cnt + 5'd1;
      if (nst == vna_pkg::N_ROOT) begin
        comp <= '0;
      end else if (div_last) begin
        comp <= comp + 2'd1;
      end
    end
  end

  // datapath: scale, sum of squares, bit-serial root, bit-serial divide
  always_ff @(posedge clk) begin
    unique case (nst)
      vna_pkg::N_IDLE: begin
        if (req.start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= req.vec[i][vna_pkg::VEC_W-1];
            mag[i] <= req.vec[i][vna_pkg::VEC_W-1] ? (~req.vec[i] + 1'b1) : req.vec[i];
          end
        end
      end
      vna_pkg::N_SCALE: begin
        if (m == '0) begin
          nonzero <= 1'b0;
          nout    <= '0;
        end else if (m[vna_pkg::MAG_W-1:vna_pkg::SCL_W] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!m[vna_pkg::SCL_W-1]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end else begin
          nonzero <= 1'b1;
          rem     <= '0;
        end
      end
      vna_pkg::N_SQ: begin
        if (cnt < 5'd3) begin
          prod <= mag[sel][vna_pkg::SCL_W-1:0] * mag[sel][vna_pkg::SCL_W-1:0];
        end
        if (cnt != 5'd0) begin
          rem <= rem + vna_pkg::SQ_W'(prod);
        end
        root <= '0;
        bitr <= vna_pkg::SQ_W'(1) << (vna_pkg::SQ_W - 1);
      end
      vna_pkg::N_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitr;
        end else begin
          root <= root >> 1;
        end
        bitr <= bitr >> 2;
      end
      vna_pkg::N_DIV: begin
        if (cnt == 5'd0) begin
          drem <= num;
          dvs  <= vna_pkg::DV_W'(root[vna_pkg::LEN_W-1:0]) << (vna_pkg::Q_W - 1);
          q    <= '0;
        end else if (cnt == 5'd17) begin
          nout[comp] <= neg[comp] ? (~qc + 1'b1) : qc;
        end else begin
          if (drem >= dvs) begin
            drem <= drem - dvs;
            q    <= {q[vna_pkg::Q_W-2:0], 1'b1};
          end else begin
            q    <= {q[vna_pkg::Q_W-2:0], 1'b0};
          end
          dvs <= dvs >> 1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/vna_checker.sv */
module vna_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic signed [vna_pkg::NRM_W-1:0]  normal_x,
  input logic signed [vna_pkg::NRM_W-1:0]  normal_y,
  input logic signed [vna_pkg::NRM_W-1:0]  normal_z,
  input logic                              used_default
);

  // clearing sweep follows reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("cmd ready right after reset");

  // pending result is held until transferred
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // default normal is (0,0,1)
  a_default_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && used_default |->
      normal_x == 0 && normal_y == 0 && normal_z == 16384)
    else $error("default normal has wrong value");

  // computed components stay within unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !used_default |->
      normal_x >= -16384 && normal_x <= 16384 &&
      normal_y >= -16384 && normal_y <= 16384 &&
      normal_z >= -16384 && normal_z <= 16384)
    else $error("normal component out of range");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .normal_x     (res.normal_x),
  .normal_y     (res.normal_y),
  .normal_z     (res.normal_z),
  .used_default (res.used_default)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic signed [vna_pkg::NRM_W-1:0] nx;
    logic signed [vna_pkg::NRM_W-1:0] ny;
    logic signed [vna_pkg::NRM_W-1:0] nz;
    logic                             dflt;
    logic                             sat;
  } normal_t;

  typedef struct {
    vna_pkg::func_t             fn;
    logic [vna_pkg::IDX_W-1:0]  idx;
    logic [15:0]                px;
    logic [15:0]                py;
    logic [15:0]                pz;
    logic [vna_pkg::IDX_W-1:0]  c0;
    logic [vna_pkg::IDX_W-1:0]  c1;
    logic [vna_pkg::IDX_W-1:0]  c2;
    logic                       fixed;
    normal_t                    want;
  } cmd_row_t;

  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vna_cmd_if cmd ();
  vna_res_if res ();

  vertex_normal_accumulator u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd.sink),
    .res (res.source)
  );

  // mirror of the block's state
  logic signed [vna_pkg::COORD_W-1:0] pos_mem [vna_pkg::VERTEX_DEPTH][3];
  logic signed [vna_pkg::SUM_W-1:0]   acc_sum [vna_pkg::VERTEX_DEPTH][3];
  logic [vna_pkg::CNT_W-1:0]          acc_cnt [vna_pkg::VERTEX_DEPTH];

  normal_t  normals_due [$];
  cmd_row_t steps [$];
  int       errors = 0;
  int       sent = 0;
  longint   cycles = 0;
  bit       hold_off = 1'b0;
  bit       sending_done = 1'b0;

  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("vertex_normal_accumulator regression: fail");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic add_step(input cmd_row_t r);
    steps.insert(steps.size(), r);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= root + b) begin
        s -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // scale to unit length in q1.14; returns 0 for the zero vector
  function automatic bit unit_q14(input longint v [3], output int q [3]);
    longint unsigned mag [3];
    longint unsigned m;
    longint unsigned s2;
    longint unsigned len;
    longint unsigned r;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
      q[i] = 0;
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += mag[i] * mag[i];
    len = int_sqrt(s2);
    for (int i = 0; i < 3; i++) begin
      r = (mag[i] * 16384 + len / 2) / len;
      if (r > 16384) r = 16384;
      q[i] = v[i] < 0 ? -int'(r) : int'(r);
    end
    return 1;
  endfunction

  function automatic logic signed [vna_pkg::SUM_W-1:0] sum_sat(input longint a, input longint b);
    longint r;
    r = a + b;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[vna_pkg::SUM_W-1:0];
  endfunction

  // apply one command to the mirror; returns 1 with a normal for reads
  function automatic bit apply_cmd(input cmd_row_t c, output normal_t n);
    longint a [3];
    longint b [3];
    longint v [3];
    int     q [3];
    int     k [3];
    n = '{nx: 0, ny: 0, nz: 16'sd16384, dflt: 1'b1, sat: 1'b0};
    case (c.fn)
      vna_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < vna_pkg::VERTEX_DEPTH; i++) begin
          acc_cnt[i] = '0;
          for (int j = 0; j < 3; j++) acc_sum[i][j] = '0;
        end
        return 0;
      end
      vna_pkg::FUNC_WRITE: begin
        pos_mem[c.idx][0] = c.px;
        pos_mem[c.idx][1] = c.py;
        pos_mem[c.idx][2] = c.pz;
        return 0;
      end
      vna_pkg::FUNC_TRIANGLE: begin
        k = '{int'(c.c0), int'(c.c1), int'(c.c2)};
        for (int i = 0; i < 3; i++) begin
          a[i] = longint'(pos_mem[k[1]][i]) - longint'(pos_mem[k[0]][i]);
          b[i] = longint'(pos_mem[k[1]][i]) - longint'(pos_mem[k[2]][i]);
        end
        v[0] = a[1] * b[2] - a[2] * b[1];
        v[1] = a[2] * b[0] - a[0] * b[2];
        v[2] = a[0] * b[1] - a[1] * b[0];
        void'(unit_q14(v, q));
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) acc_sum[k[i]][j] = sum_sat(acc_sum[k[i]][j], q[j]);
          if (acc_cnt[k[i]] != vna_pkg::COUNT_MAX) acc_cnt[k[i]]++;
        end
        return 0;
      end
      default: begin
        n.sat = acc_cnt[c.idx] == vna_pkg::COUNT_MAX;
        if (acc_cnt[c.idx] != 0) begin
          for (int j = 0; j < 3; j++) v[j] = acc_sum[c.idx][j];
          if (unit_q14(v, q)) begin
            n.nx = vna_pkg::NRM_W'(q[0]);
            n.ny = vna_pkg::NRM_W'(q[1]);
            n.nz = vna_pkg::NRM_W'(q[2]);
            n.dflt = 1'b0;
          end
        end
        return 1;
      end
    endcase
  endfunction

  function automatic cmd_row_t mk(input vna_pkg::func_t fn, input int idx, input int px,
                                  input int py, input int pz, input int c0, input int c1,
                                  input int c2);
    cmd_row_t r;
    r.fn = fn;
    r.idx = vna_pkg::IDX_W'(idx);
    r.px = 16'(px);
    r.py = 16'(py);
    r.pz = 16'(pz);
    r.c0 = vna_pkg::IDX_W'(c0);
    r.c1 = vna_pkg::IDX_W'(c1);
    r.c2 = vna_pkg::IDX_W'(c2);
    r.fixed = 1'b0;
    r.want = '{nx: 0, ny: 0, nz: 0, dflt: 0, sat: 0};
    return r;
  endfunction

  function automatic cmd_row_t mk_read(input int idx, input bit fixed, input normal_t want);
    cmd_row_t r;
    r = mk(vna_pkg::FUNC_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  // random write to a small working set so triangles hit written vertices
  function automatic cmd_row_t rand_write(input int idx);
    int s;
    s = $urandom_range(0, 3);
    if (s == 0) return mk(vna_pkg::FUNC_WRITE, idx, $urandom, $urandom, $urandom, 0, 0, 0);
    return mk(vna_pkg::FUNC_WRITE, idx, $urandom_range(0, 1023) - 512,
              $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
              $urandom, $urandom, $urandom);
  endfunction

  task automatic build_directed();
    normal_t dn;
    dn = '{nx: 0, ny: 0, nz: 16'sd16384, dflt: 1'b1, sat: 1'b0};
    // fresh state reads back the default normal
    add_step(mk_read(0, 1, dn));
    add_step(mk_read(1023, 1, dn));
    // field extremes and an axis-aligned triangle
    add_step(mk(vna_pkg::FUNC_WRITE, 0, 0, 0, 0, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_WRITE, 1, 16'h7fff, 0, 0, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_WRITE, 1023, 0, 16'h7fff, 0, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, 0, 1, 1023));
    add_step(mk_read(0, 0, dn));
    add_step(mk_read(1, 0, dn));
    add_step(mk_read(1023, 0, dn));
    add_step(mk(vna_pkg::FUNC_WRITE, 2, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_WRITE, 3, 16'h7fff, 16'h7fff, 16'h8000, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, 2, 3, 1));
    add_step(mk_read(2, 0, dn));
    // degenerate triangle: zero vector counted, default on read
    add_step(mk(vna_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, 2, 2, 2));
    add_step(mk_read(2, 1, dn));
    // opposite faces cancel: sum zero gives the default
    add_step(mk(vna_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, 0, 1, 1023));
    add_step(mk(vna_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, 1023, 1, 0));
    add_step(mk_read(1, 1, dn));
    add_step(mk(vna_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    add_step(mk_read(0, 1, dn));
  endtask

  // enough hits on one vertex to saturate its face count
  task automatic build_saturation();
    add_step(mk(vna_pkg::FUNC_WRITE, 10, 0, 0, 0, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_WRITE, 11, 16'h0100, 0, 0, 0, 0, 0));
    add_step(mk(vna_pkg::FUNC_WRITE, 12, 0, 16'h0100, 0, 0, 0, 0));
    for (int i = 0; i < 260; i++) begin
      add_step(mk(vna_pkg::FUNC_TRIANGLE, 0, 0, 0, 0, 10, 11, 12));
      if (i == 253 || i == 254 || i == 259)
        add_step(mk_read(10, 0, '{0, 0, 0, 0, 0}));
    end
  endtask

  task automatic build_random(input int n);
    int wset;
    int r;
    wset = 16;
    for (int i = 0; i < 4; i++) add_step(rand_write(i));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) add_step(mk(vna_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
      else if (r < 25) begin
        if ($urandom_range(0, 9) == 0) add_step(rand_write($urandom_range(0, 1023)));
        else add_step(rand_write($urandom_range(0, wset - 1)));
      end else if (r < 60) begin
        add_step(mk(vna_pkg::FUNC_TRIANGLE, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3)));
      end else begin
        add_step(mk_read($urandom_range(0, 1) ? $urandom_range(0, wset - 1)
                         : $urandom_range(0, 1023), 0, '{0, 0, 0, 0, 0}));
      end
    end
  endtask

  // drop triangles whose corners were never written
  task automatic screen_steps();
    bit seen [vna_pkg::VERTEX_DEPTH];
    cmd_row_t kept [$];
    foreach (steps[i]) begin
      if (steps[i].fn == vna_pkg::FUNC_WRITE) seen[steps[i].idx] = 1'b1;
      if (steps[i].fn != vna_pkg::FUNC_TRIANGLE ||
          (seen[steps[i].c0] && seen[steps[i].c1] && seen[steps[i].c2]))
        kept.insert(kept.size(), steps[i]);
    end
    steps = kept;
  endtask

  // sender: bursts and gaps
  initial begin
    normal_t n;
    int      burst;
    cmd.valid = 1'b0;
    cmd.func = '0;
    cmd.vertex_index = '0;
    cmd.pos_x = '0;
    cmd.pos_y = '0;
    cmd.pos_z = '0;
    cmd.first_corner = '0;
    cmd.second_corner = '0;
    cmd.third_corner = '0;
    build_directed();
    build_saturation();
    build_random(260);
    screen_steps();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    burst = 0;
    foreach (steps[i]) begin
      if (burst == 0) begin
        cmd.valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
      cmd.valid = 1'b1;
      cmd.func = steps[i].fn;
      cmd.vertex_index = steps[i].idx;
      cmd.pos_x = steps[i].px;
      cmd.pos_y = steps[i].py;
      cmd.pos_z = steps[i].pz;
      cmd.first_corner = steps[i].c0;
      cmd.second_corner = steps[i].c1;
      cmd.third_corner = steps[i].c2;
      do @(posedge clk); while (!cmd.ready);
      sent++;
      if (apply_cmd(steps[i], n)) begin
        normals_due.insert(normals_due.size(), steps[i].fixed ? steps[i].want : n);
      end
      burst--;
      @(negedge clk);
    end
    cmd.valid = 1'b0;
    sending_done = 1'b1;
  end

  // one long hold-off during the random part while the sender keeps offering
  initial begin
    wait (sent >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) res.ready <= 1'b0;
    else if (hold_off) res.ready <= 1'b0;
    else if (cycles[9:8] == 2'b00) res.ready <= 1'b1;
    else res.ready <= ($urandom_range(0, 3) != 0);
  end

  // result check on each transfer
  always @(posedge clk) begin
    normal_t w;
    if (!rst && res.valid && res.ready) begin
      if (normals_due.size() == 0) begin
        report("unexpected result", res.normal_x, 0);
      end else begin
        w = normals_due.pop_front();
        if (res.normal_x !== w.nx) report("normal_x", res.normal_x, w.nx);
        if (res.normal_y !== w.ny) report("normal_y", res.normal_y, w.ny);
        if (res.normal_z !== w.nz) report("normal_z", res.normal_z, w.nz);
        if (res.used_default !== w.dflt) report("used_default", res.used_default, w.dflt);
        if (res.count_saturated !== w.sat)
          report("count_saturated", res.count_saturated, w.sat);
      end
    end
  end

  // end of run
  initial begin
    wait (sending_done);
    wait (normals_due.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && normals_due.size() == 0)
      $display("vertex_normal_accumulator regression: pass");
    else
      $display("vertex_normal_accumulator regression: fail");
    $finish;
  end

endmodule

/* sim.f */
src/vna_pkg.sv
src/vna_cmd_if.sv
src/vna_res_if.sv
src/vna_ram.sv
src/vna_norm.sv
src/vertex_normal_accumulator.sv
src/vna_checker.sv
tb/testbench.sv
